// ===== hw/rtl/u8d_pkg.sv =====
package u8d_pkg;

  localparam logic [7:0] CONT_LOW       = 8'h80;
  localparam logic [7:0] CONT_HIGH      = 8'hBF;
  localparam logic [7:0] E0_SECOND_LOW  = 8'hA0;
  localparam logic [7:0] ED_SECOND_HIGH = 8'h9F;
  localparam logic [7:0] F0_SECOND_LOW  = 8'h90;
  localparam logic [7:0] F4_SECOND_HIGH = 8'h8F;
  localparam logic [7:0] LEAD2_LOW      = 8'hC2;
  localparam logic [7:0] LEAD2_HIGH     = 8'hDF;
  localparam logic [7:0] LEAD3_LOW      = 8'hE0;
  localparam logic [7:0] LEAD3_HIGH     = 8'hEF;
  localparam logic [7:0] LEAD4_LOW      = 8'hF0;
  localparam logic [7:0] LEAD4_HIGH     = 8'hF4;
  localparam logic [7:0] LEAD_E0        = 8'hE0;
  localparam logic [7:0] LEAD_ED        = 8'hED;
  localparam logic [7:0] LEAD_F0        = 8'hF0;
  localparam logic [7:0] LEAD_F4        = 8'hF4;
  localparam logic [5:0] HIGH_SUR_TAG   = 6'b110110;
  localparam logic [5:0] LOW_SUR_TAG    = 6'b110111;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;

  localparam int unsigned CODE_W = 21;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    status_t           status;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]        rem;
    logic [CODE_W-1:0] partial;
    logic [7:0]        second_lo;
    logic [7:0]        second_hi;
    logic              await_second;
    logic              halted;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    rem: 2'd0, partial: '0, second_lo: CONT_LOW, second_hi: CONT_HIGH,
    await_second: 1'b0, halted: 1'b0
  };

endpackage

// ===== hw/rtl/u8d_decode.sv =====
module u8d_decode (
  input  u8d_pkg::dec_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                eos,
  input  logic                utf16,
  output u8d_pkg::dec_state_t st_nxt,
  output logic [1:0]          n_res,
  output u8d_pkg::result_t    res0,
  output u8d_pkg::result_t    res1
);
  import u8d_pkg::*;

  logic [7:0]        lo;
  logic [7:0]        hi;
  logic [CODE_W-1:0] shifted;
  logic [CODE_W-1:0] cp;
  logic [19:0]       supp;
  logic              emit_cp;
  logic              emit_err;
  logic              emit_trunc;
  logic [1:0]        rem_dec;

  assign lo      = st.await_second ? st.second_lo : CONT_LOW;
  assign hi      = st.await_second ? st.second_hi : CONT_HIGH;
  assign shifted = {st.partial[CODE_W-7:0], data_byte[5:0]};
  assign rem_dec = st.rem - 2'd1;
  assign cp      = (st.rem == 2'd0) ? {13'd0, data_byte} : shifted;
  assign supp    = 20'(cp - SUPP_BASE);

  always_comb begin
    st_nxt     = st;
    emit_cp    = 1'b0;
    emit_err   = 1'b0;
    emit_trunc = 1'b0;
    if (st.halted) begin
      if (eos) begin
        st_nxt = STATE_RESET;
      end
    end else if (st.rem == 2'd0) begin
      st_nxt.await_second = 1'b1;
      priority if (data_byte < CONT_LOW) begin
        st_nxt  = st;
        emit_cp = 1'b1;
      end else if (data_byte >= LEAD2_LOW && data_byte <= LEAD2_HIGH) begin
        st_nxt.rem     = 2'd1;
        st_nxt.partial = {16'd0, data_byte[4:0]};
      end else if (data_byte >= LEAD3_LOW && data_byte <= LEAD3_HIGH) begin
        st_nxt.rem     = 2'd2;
        st_nxt.partial = {17'd0, data_byte[3:0]};
        if (data_byte == LEAD_E0) begin
          st_nxt.second_lo = E0_SECOND_LOW;
        end
        if (data_byte == LEAD_ED) begin
          st_nxt.second_hi = ED_SECOND_HIGH;
        end
      end else if (data_byte >= LEAD4_LOW && data_byte <= LEAD4_HIGH) begin
        st_nxt.rem     = 2'd3;
        st_nxt.partial = {18'd0, data_byte[2:0]};
        if (data_byte == LEAD_F0) begin
          st_nxt.second_lo = F0_SECOND_LOW;
        end
        if (data_byte == LEAD_F4) begin
          st_nxt.second_hi = F4_SECOND_HIGH;
        end
      end else begin
        emit_err = 1'b1;
      end
      if (!emit_cp && !emit_err && eos) begin
        st_nxt     = STATE_RESET;
        emit_trunc = 1'b1;
      end
    end else if (data_byte < lo || data_byte > hi) begin
      emit_err = 1'b1;
    end else if (rem_dec == 2'd0) begin
      st_nxt  = STATE_RESET;
      emit_cp = 1'b1;
    end else if (eos) begin
      st_nxt     = STATE_RESET;
      emit_trunc = 1'b1;
    end else begin
      st_nxt.partial      = shifted;
      st_nxt.rem          = rem_dec;
      st_nxt.await_second = 1'b0;
    end
    if (emit_err) begin
      st_nxt        = STATE_RESET;
      st_nxt.halted = !eos;
    end
  end

  always_comb begin
    n_res       = 2'd0;
    res0.code   = '0;
    res0.status = ST_VALID;
    res0.last   = 1'b1;
    res1.code   = {5'd0, LOW_SUR_TAG, supp[9:0]};
    res1.status = ST_VALID;
    res1.last   = 1'b1;
    if (emit_err) begin
      n_res       = 2'd1;
      res0.status = ST_ILLEGAL;
    end else if (emit_trunc) begin
      n_res       = 2'd1;
      res0.status = ST_TRUNC;
    end else if (emit_cp) begin
      if (utf16 && cp[20:16] != 5'd0) begin
        n_res     = 2'd2;
        res0.code = {5'd0, HIGH_SUR_TAG, supp[19:10]};
        res0.last = 1'b0;
      end else begin
        n_res     = 2'd1;
        res0.code = cp;
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_validating_decoder.sv =====
// Channel  Direction  tdata                            tlast           tuser
// in_      slave      [7:0] data_byte                  end_of_stream   -
// out_     master     [20:0] code_value, [22:21] status last_of_run    -
// cfg_     write      cfg_wr_data = utf16_output       -               -
// One byte is accepted per cycle unless its result waits for a stalled output or a pending
// low surrogate; a byte enters an input register and is decoded into the output register.
// A surrogate pair holds the input while the low unit waits to be sent.
// Bytes that give no result pass even while the output is stalled.
// Reset (rst_n low, synchronous) clears all sequence state and selects UTF-32.
module utf8_validating_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_value, [22:21] status, [23] zero
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import u8d_pkg::*;

  logic       utf16_r;
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       eos_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  logic [1:0] n_res;
  result_t    res0;
  result_t    res1;
  logic       out_vld_r;
  result_t    out_r;
  logic       pend_vld_r;
  result_t    pend_r;
  logic       out_free;
  logic       fire;

  u8d_decode u_dec (
    .st        (st_r),
    .data_byte (byte_r),
    .eos       (eos_r),
    .utf16     (utf16_r),
    .st_nxt    (st_nxt),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1)
  );

  assign out_free  = !out_vld_r || out_tready;
  assign fire      = in_vld_r && (n_res == 2'd0 || (out_free && !pend_vld_r));
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf16_r    <= 1'b0;
      in_vld_r   <= 1'b0;
      st_r       <= STATE_RESET;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        utf16_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
        byte_r   <= in_tdata;
        eos_r    <= in_tlast;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
      if (fire && n_res != 2'd0) begin
        out_vld_r  <= 1'b1;
        out_r      <= res0;
        pend_vld_r <= (n_res == 2'd2);
        pend_r     <= res1;
      end else if (out_free && pend_vld_r) begin
        out_vld_r  <= 1'b1;
        out_r      <= pend_r;
        pend_vld_r <= 1'b0;
      end else if (out_free) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_r.status, out_r.code};
  assign out_tlast  = out_r.last;

endmodule

// ===== hw/rtl/u8d_checker.sv =====
module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import u8d_pkg::*;

  a_err_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22:21] != ST_VALID |-> out_tdata[20:0] == '0)
    else $error("error item carries a nonzero code value");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22:21] != ST_VALID |-> out_tlast)
    else $error("error item not marked last");

  a_first_is_high_sur: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[20:10] == {5'd0, HIGH_SUR_TAG})
    else $error("non-last item is not a high surrogate");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tlast && out_tdata[20:10] == {5'd0, LOW_SUR_TAG})
    else $error("low surrogate does not follow the high one");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

endmodule

bind utf8_validating_decoder u8d_checker u_u8d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/utf8_decode_checker.sv =====
`timescale 1ns / 100ps

module utf8_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned bytes_decoded
);

  import u8d_pkg::*;

  logic        utf16_mode;
  logic [1:0]  seq_left;
  logic [20:0] seq_acc;
  logic [7:0]  second_lo;
  logic [7:0]  second_hi;
  logic        want_second;
  logic        dropping;
  result_t     expected_units[$];
  int unsigned err_total = 0;
  int unsigned decoded_total = 0;

  task automatic clear_seq();
    seq_left    = 2'd0;
    seq_acc     = '0;
    second_lo   = CONT_LOW;
    second_hi   = CONT_HIGH;
    want_second = 1'b0;
  endtask

  task automatic push_unit(input logic [20:0] code, input status_t st, input logic last);
    result_t u;
    u.code   = code;
    u.status = st;
    u.last   = last;
    expected_units.push_back(u);
  endtask

  task automatic push_char(input logic [20:0] cp);
    logic [19:0] offset;
    if (utf16_mode && cp >= SUPP_BASE) begin
      offset = 20'(cp - SUPP_BASE);
      push_unit({5'd0, HIGH_SUR_TAG, offset[19:10]}, ST_VALID, 1'b0);
      push_unit({5'd0, LOW_SUR_TAG, offset[9:0]}, ST_VALID, 1'b1);
    end else begin
      push_unit(cp, ST_VALID, 1'b1);
    end
  endtask

  task automatic push_illegal(input logic eos);
    clear_seq();
    dropping = !eos;
    push_unit('0, ST_ILLEGAL, 1'b1);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] cp;
    decoded_total++;
    if (dropping) begin
      if (eos) begin
        dropping = 1'b0;
        clear_seq();
      end
      return;
    end
    if (seq_left == 2'd0) begin
      if (b < CONT_LOW) begin
        push_char({13'd0, b});
        return;
      end
      if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
        seq_left = 2'd1;
        seq_acc  = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
        seq_left = 2'd2;
        seq_acc  = {17'd0, b[3:0]};
        if (b == LEAD_E0) second_lo = E0_SECOND_LOW;
        if (b == LEAD_ED) second_hi = ED_SECOND_HIGH;
      end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
        seq_left = 2'd3;
        seq_acc  = {18'd0, b[2:0]};
        if (b == LEAD_F0) second_lo = F0_SECOND_LOW;
        if (b == LEAD_F4) second_hi = F4_SECOND_HIGH;
      end else begin
        push_illegal(eos);
        return;
      end
      want_second = 1'b1;
      if (eos) begin
        clear_seq();
        push_unit('0, ST_TRUNC, 1'b1);
      end
      return;
    end
    lo = want_second ? second_lo : CONT_LOW;
    hi = want_second ? second_hi : CONT_HIGH;
    if (b < lo || b > hi) begin
      push_illegal(eos);
      return;
    end
    seq_acc     = {seq_acc[14:0], b[5:0]};
    seq_left    = seq_left - 2'd1;
    want_second = 1'b0;
    if (seq_left == 2'd0) begin
      cp = seq_acc;
      clear_seq();
      push_char(cp);
    end else if (eos) begin
      clear_seq();
      push_unit('0, ST_TRUNC, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    result_t head;
    if (!rst_n) begin
      utf16_mode = 1'b0;
      dropping   = 1'b0;
      clear_seq();
      expected_units.delete();
    end else begin
      if (cfg_wr_en) utf16_mode = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (expected_units.size() == 0) begin
          $error("result with no expectation: code_value %0h status %0d last_of_run %0b",
                 out_tdata[20:0], out_tdata[22:21], out_tlast);
          err_total++;
        end else begin
          head = expected_units.pop_front();
          if (out_tdata[20:0] !== head.code) begin
            $error("code_value: expected %0h, got %0h", head.code, out_tdata[20:0]);
            err_total++;
          end
          if (out_tdata[22:21] !== head.status) begin
            $error("status: expected %0d, got %0d", head.status, out_tdata[22:21]);
            err_total++;
          end
          if (out_tlast !== head.last) begin
            $error("last_of_run: expected %0b, got %0b", head.last, out_tlast);
            err_total++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    mismatches    <= err_total;
    pending       <= expected_units.size();
    bytes_decoded <= decoded_total;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  import u8d_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        steady;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned bytes_decoded;
  int          stall_left = 0;
  int          idle_cycles = 0;

  utf8_validating_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  utf8_decode_checker decode_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .bytes_decoded(bytes_decoded)
  );

  always #6 clk = ~clk;

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left <= pick_stall() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** utf8_validating_decoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic eos);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 65) ? 0 : pick_stall();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_char();
    logic [7:0] seq [4];
    logic [7:0] lo;
    logic [7:0] hi;
    int         n;
    int         r;
    r  = $urandom_range(0, 99);
    lo = CONT_LOW;
    hi = CONT_HIGH;
    if (r < 40) begin
      n = 1;
      seq[0] = 8'($urandom_range(0, 8'h7F));
    end else if (r < 55) begin
      n = 2;
      seq[0] = 8'($urandom_range(LEAD2_LOW, LEAD2_HIGH));
    end else if (r < 75) begin
      n = 3;
      seq[0] = 8'($urandom_range(LEAD3_LOW, LEAD3_HIGH));
      if (seq[0] == LEAD_E0) lo = E0_SECOND_LOW;
      if (seq[0] == LEAD_ED) hi = ED_SECOND_HIGH;
    end else if (r < 88) begin
      n = 4;
      seq[0] = 8'($urandom_range(LEAD4_LOW, LEAD4_HIGH));
      if (seq[0] == LEAD_F0) lo = F0_SECOND_LOW;
      if (seq[0] == LEAD_F4) hi = F4_SECOND_HIGH;
    end else begin
      n = 1;
      seq[0] = 8'($urandom_range(0, 255));
    end
    seq[1] = 8'($urandom_range(lo, hi));
    seq[2] = 8'($urandom_range(CONT_LOW, CONT_HIGH));
    seq[3] = 8'($urandom_range(CONT_LOW, CONT_HIGH));
    if (n > 1 && $urandom_range(0, 99) < 12) seq[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
    if (n > 1 && $urandom_range(0, 99) < 5) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) send_byte(seq[i], $urandom_range(0, 99) < 6);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic utf16);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= utf16;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    int          chars;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    steady      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(LEAD2_LOW, 1'b0); send_byte(CONT_LOW, 1'b0);
    send_byte(LEAD_E0, 1'b0); send_byte(E0_SECOND_LOW, 1'b0); send_byte(CONT_LOW, 1'b0);
    send_byte(LEAD_ED, 1'b0); send_byte(ED_SECOND_HIGH, 1'b0); send_byte(CONT_HIGH, 1'b0);
    send_byte(LEAD_F0, 1'b0); send_byte(F0_SECOND_LOW, 1'b0);
    send_byte(CONT_LOW, 1'b0); send_byte(CONT_LOW, 1'b0);
    send_byte(LEAD_F4, 1'b0); send_byte(F4_SECOND_HIGH, 1'b0);
    send_byte(CONT_HIGH, 1'b0); send_byte(CONT_HIGH, 1'b0);
    // A bad lead byte halts decoding until the end of the stream.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(LEAD_E0, 1'b0); send_byte(8'h9F, 1'b1);
    send_byte(8'hE1, 1'b0); send_byte(CONT_LOW, 1'b1);
    send_byte(8'hC1, 1'b1);
    send_byte(8'hF1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      set_mode(phase != 1);
      target = bytes_decoded + 580;
      chars  = 0;
      while (bytes_decoded < target) begin
        steady <= ((chars / 150) % 4) == 3;
        send_char();
        chars++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("** utf8_validating_decoder: PASSED **");
    end else begin
      $display("** utf8_validating_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== utf8_validating_decoder.f =====
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_decode.sv
hw/rtl/utf8_validating_decoder.sv
hw/rtl/u8d_checker.sv
tb/utf8_decode_checker.sv
tb/tb_top.sv
